// ===== hw/rtl/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the snooping coherence controller.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int LINES      = 64;
  localparam int IDX_W      = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int LAT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Transaction codes.
  localparam logic [2:0] MODE_RD      = 3'd0;
  localparam logic [2:0] MODE_WR      = 3'd1;
  localparam logic [2:0] MODE_BUSRD   = 3'd2;
  localparam logic [2:0] MODE_BUSRDX  = 3'd3;
  localparam logic [2:0] MODE_BUSUPGR = 3'd4;

  // Bus request codes.
  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_RD    = 2'd1;
  localparam logic [1:0] BUS_RDX   = 2'd2;
  localparam logic [1:0] BUS_UPGR  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_HIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_HIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER = 3'd5;

  typedef enum logic [2:0] {
    ST_I = 3'd0,
    ST_S = 3'd1,
    ST_E = 3'd2,
    ST_M = 3'd3,
    ST_O = 3'd4
  } line_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LOOK,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_FILL
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic use_scan_victim;
  } scc_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } scc_status_t;

endpackage

// ===== hw/rtl/scc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_if
// Handshake channels for incoming transactions and for results.
// ----------------------------------------------------------------------------
interface scc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] line_address;
  logic        copy_elsewhere;

  modport source(output valid, mode, line_address, copy_elsewhere, input ready);
  modport sink(input valid, mode, line_address, copy_elsewhere, output ready);
endinterface

interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_request;
  logic [7:0] latency;
  logic       hit;
  logic       flush;
  logic       invalidated;
  logic       memory_access;
  logic       writeback;
  logic       protocol_error;

  modport source(output valid, bus_request, latency, hit, flush, invalidated,
                 memory_access, writeback, protocol_error, input ready);
  modport sink(input valid, bus_request, latency, hit, flush, invalidated,
               memory_access, writeback, protocol_error, output ready);
endinterface

// ===== hw/rtl/snooping_coherence_controller.sv =====
`timescale 1ns / 1ps
// A hit, snoop or invalid-line fill commits from lookup once the result register is free.
// A miss with every line valid first scans the fill stamp RAM, one entry per cycle.
// Throughput: one transaction at a time; the next is accepted once the current one commits.
// The result register lets a new transaction enter while the previous result waits.
// Reset (synchronous, active low) invalidates all lines, clears the fill counter and
// restores the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// snooping_coherence_controller
// MESI/MOESI snooping coherence controller for one fully associative cache.
// ----------------------------------------------------------------------------
module snooping_coherence_controller import scc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  scc_in_if.sink                in_ch,
  scc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  scc_cmd_t    cmd;
  scc_status_t status;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  scc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_ch.mode),
    .in_line_address    (in_ch.line_address),
    .in_copy_elsewhere  (in_ch.copy_elsewhere),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_bus_request    (out_ch.bus_request),
    .out_latency        (out_ch.latency),
    .out_hit            (out_ch.hit),
    .out_flush          (out_ch.flush),
    .out_invalidated    (out_ch.invalidated),
    .out_memory_access  (out_ch.memory_access),
    .out_writeback      (out_ch.writeback),
    .out_protocol_error (out_ch.protocol_error)
  );

endmodule

// ===== hw/rtl/scc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/scc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: lookup, optional victim scan, commit into the result register.
// ----------------------------------------------------------------------------
module scc_ctrl import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  scc_status_t status,
  output scc_cmd_t    cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) state_nxt = FSM_LOOK;
      end
      FSM_LOOK: begin
        if (status.need_scan) state_nxt = FSM_SCAN;
        else if (status.out_free) state_nxt = FSM_IDLE;
      end
      FSM_SCAN: begin
        if (status.scan_last) state_nxt = FSM_DRAIN;
      end
      FSM_DRAIN: state_nxt = FSM_FILL;
      FSM_FILL: begin
        if (status.out_free) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      FSM_LOOK: begin
        cmd.scan_start = status.need_scan;
        cmd.commit     = !status.need_scan && status.out_free;
      end
      FSM_SCAN: cmd.scan_step = 1'b1;
      FSM_DRAIN: ;
      FSM_FILL: begin
        cmd.commit          = status.out_free;
        cmd.use_scan_victim = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/scc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_dp
// Line tags, line states, fill stamps, configuration and result register.
// ----------------------------------------------------------------------------
module scc_dp import scc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [2:0]            in_mode,
  input  logic [ADDR_W-1:0]     in_line_address,
  input  logic                  in_copy_elsewhere,
  input  scc_cmd_t              cmd,
  output scc_status_t           status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_bus_request,
  output logic [LAT_W-1:0]      out_latency,
  output logic                  out_hit,
  output logic                  out_flush,
  output logic                  out_invalidated,
  output logic                  out_memory_access,
  output logic                  out_writeback,
  output logic                  out_protocol_error
);

  // Configuration.
  logic             proto_r;
  logic [3:0]       offset_r;
  logic [LAT_W-1:0] rd_hit_r, wr_hit_r, mem_lat_r, xfer_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r    <= 1'b0;
      offset_r   <= 4'd6;
      rd_hit_r   <= 8'd1;
      wr_hit_r   <= 8'd1;
      mem_lat_r  <= 8'd100;
      xfer_lat_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROTOCOL: proto_r    <= cfg_wdata[0];
        CFG_OFFSET:   offset_r   <= cfg_wdata[3:0];
        CFG_RD_HIT:   rd_hit_r   <= cfg_wdata;
        CFG_WR_HIT:   wr_hit_r   <= cfg_wdata;
        CFG_MEMORY:   mem_lat_r  <= cfg_wdata;
        CFG_TRANSFER: xfer_lat_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Captured transaction.
  logic [2:0]       mode_r;
  logic [TAG_W-1:0] tag_r;
  logic             copy_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      tag_r  <= in_line_address >> offset_r;
      copy_r <= in_copy_elsewhere;
    end
  end

  // Per-line tag and state registers, each compared in its own lane.
  logic [TAG_W-1:0] tags_r   [LINES];
  line_state_t      states_r [LINES];
  logic [LINES-1:0] match;
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  line_state_t      s_hit;
  logic             has_inv;
  logic [IDX_W-1:0] inv_idx;

  always_comb begin
    hit_idx = '0;
    s_hit   = ST_I;
    has_inv = 1'b0;
    inv_idx = '0;
    for (int i = 0; i < LINES; i++) begin
      match[i] = (states_r[i] != ST_I) && (tags_r[i] == tag_r);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        s_hit   = line_state_t'(s_hit | states_r[i]);
      end
    end
    // Lowest invalid line wins.
    for (int i = LINES - 1; i >= 0; i--) begin
      if (states_r[i] == ST_I) begin
        has_inv = 1'b1;
        inv_idx = IDX_W'(i);
      end
    end
  end
  assign hit_any = |match;

  logic is_proc, is_snoop;
  assign is_proc  = (mode_r == MODE_RD) || (mode_r == MODE_WR);
  assign is_snoop = (mode_r == MODE_BUSRD) || (mode_r == MODE_BUSRDX) ||
                    (mode_r == MODE_BUSUPGR);

  // Victim scan over the fill stamps, one entry per cycle.
  logic [IDX_W-1:0]   scan_cnt_r, cmp_idx_r, best_idx_r;
  logic               cmp_vld_r;
  logic [STAMP_W-1:0] best_r, stamp_rd;
  logic [STAMP_W-1:0] fill_counter_r;
  logic [IDX_W-1:0]   victim;
  logic [IDX_W-1:0]   ram_addr;
  logic               ram_we;

  assign victim   = cmd.use_scan_victim ? best_idx_r : inv_idx;
  assign ram_addr = cmd.commit ? victim : scan_cnt_r;

  // Every line is valid whenever the scan runs, so every stamp read was written.
  scc_ram #(.WIDTH(STAMP_W), .DEPTH(LINES)) u_stamps (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (fill_counter_r),
    .rdata (stamp_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_cnt_r <= '0;
      best_r     <= '1;
      best_idx_r <= '0;
    end else begin
      if (cmd.scan_step) begin
        scan_cnt_r <= scan_cnt_r + IDX_W'(1);
        cmp_idx_r  <= scan_cnt_r;
      end
      if (cmp_vld_r && (stamp_rd <= best_r)) begin
        best_r     <= stamp_rd;
        best_idx_r <= cmp_idx_r;
      end
    end
  end

  assign status.need_scan = is_proc && !hit_any && !has_inv;
  assign status.scan_last = (scan_cnt_r == IDX_W'(LINES - 1));
  assign status.out_free  = !out_valid || out_ready;

  // Result and line update.
  line_state_t      s_vict;
  logic             st_we;
  logic [IDX_W-1:0] st_idx;
  line_state_t      st_val;
  logic             fill;
  logic [1:0]       r_bus;
  logic [LAT_W-1:0] r_lat;
  logic             r_hit, r_fl, r_inv, r_mem, r_wb, r_err;

  assign s_vict = states_r[victim];

  always_comb begin
    st_we  = 1'b0;
    st_idx = hit_idx;
    st_val = ST_I;
    fill   = 1'b0;
    r_bus  = BUS_NONE;
    r_lat  = '0;
    r_hit  = 1'b0;
    r_fl   = 1'b0;
    r_inv  = 1'b0;
    r_mem  = 1'b0;
    r_wb   = 1'b0;
    r_err  = 1'b0;
    if (is_proc) begin
      if (hit_any) begin
        r_hit = 1'b1;
        if (mode_r == MODE_RD) begin
          r_lat = rd_hit_r;
        end else begin
          r_lat  = wr_hit_r;
          if ((s_hit == ST_S) || (s_hit == ST_O)) r_bus = BUS_UPGR;
          st_we  = 1'b1;
          st_val = ST_M;
        end
      end else begin
        fill   = 1'b1;
        st_we  = 1'b1;
        st_idx = victim;
        r_wb   = (s_vict == ST_M) || (s_vict == ST_O);
        if (copy_r) begin
          r_lat = xfer_lat_r;
          r_bus = (mode_r == MODE_RD) ? BUS_RD : BUS_RDX;
        end else begin
          r_lat = mem_lat_r;
          r_mem = 1'b1;
        end
        if (mode_r == MODE_WR) st_val = ST_M;
        else st_val = copy_r ? ST_S : ST_E;
      end
    end else if (is_snoop) begin
      if (!hit_any) begin
        r_err = 1'b1;
      end else begin
        r_hit = 1'b1;
        if (mode_r == MODE_BUSRD) begin
          if (proto_r) begin
            if (s_hit == ST_E) begin
              st_we  = 1'b1;
              st_val = ST_S;
            end else if ((s_hit == ST_M) || (s_hit == ST_O)) begin
              r_fl   = 1'b1;
              st_we  = 1'b1;
              st_val = ST_O;
            end
          end else begin
            r_fl   = 1'b1;
            st_we  = 1'b1;
            st_val = ST_S;
          end
        end else if (mode_r == MODE_BUSRDX) begin
          r_fl   = !proto_r || (s_hit == ST_M) || (s_hit == ST_O);
          r_inv  = 1'b1;
          st_we  = 1'b1;
          st_val = ST_I;
        end else begin
          r_err  = (s_hit == ST_M) || (s_hit == ST_E);
          r_inv  = 1'b1;
          st_we  = 1'b1;
          st_val = ST_I;
        end
      end
    end
  end

  assign ram_we = cmd.commit && fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) states_r[i] <= ST_I;
      fill_counter_r <= '0;
    end else if (cmd.commit) begin
      if (st_we) states_r[st_idx] <= st_val;
      if (fill) fill_counter_r <= fill_counter_r + STAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && fill) tags_r[victim] <= tag_r;
  end

  // Result register.
  logic valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.commit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_bus_request    <= r_bus;
      out_latency        <= r_lat;
      out_hit            <= r_hit;
      out_flush          <= r_fl;
      out_invalidated    <= r_inv;
      out_memory_access  <= r_mem;
      out_writeback      <= r_wb;
      out_protocol_error <= r_err;
    end
  end

  assign out_valid = valid_r;

endmodule

// ===== hw/rtl/scc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks of the coherence controller.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit,
  input logic out_flush,
  input logic out_invalidated,
  input logic out_writeback,
  input logic [7:0] out_latency
);

  // A held result stays valid and keeps its latency field.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_latency))
    else $error("result changed while stalled");

  // One transaction at a time: acceptance closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // Flushes and invalidations only happen to present lines.
  a_flush_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_flush || out_invalidated) |-> out_hit)
    else $error("flush or invalidation without hit");

  // A writeback only accompanies a fill, never a hit.
  a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_writeback |-> !out_hit)
    else $error("writeback reported on a hit");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind snooping_coherence_controller scc_checker u_scc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_flush       (out_ch.flush),
  .out_invalidated (out_ch.invalidated),
  .out_writeback   (out_ch.writeback),
  .out_latency     (out_ch.latency)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the MESI/MOESI snooping coherence controller.
// A directed table covers the special cases and the reset values. Random
// phases under several register settings follow; each draws addresses from
// a pool larger than the cache, so hits, evictions and writebacks all occur.
// Every result is checked against a predictor of the line states that runs
// alongside the block, or against the value pinned in its table row.
// ----------------------------------------------------------------------------
module tb_top;
  import scc_pkg::*;

  typedef struct packed {
    logic [1:0] bus;
    logic [7:0] lat;
    logic       hit;
    logic       flush;
    logic       inv;
    logic       mem;
    logic       wb;
    logic       err;
  } coh_result_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] addr;
    logic        copy;
    logic        pinned;
    coh_result_t exp;
  } stim_row_t;

  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  scc_in_if in_ch();
  scc_out_if out_ch();

  snooping_coherence_controller uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [TAG_W-1:0]   line_tag   [LINES];
  line_state_t        line_st    [LINES];
  logic [STAMP_W-1:0] line_stamp [LINES];
  logic [STAMP_W-1:0] fill_count;
  logic               moesi_on;
  logic [3:0]         shift_bits;
  logic [7:0]         rd_hit_lat, wr_hit_lat, mem_lat, xfer_lat;

  coh_result_t expected_results[$];
  stim_row_t   stim_table[$];
  logic        pin_next = 1'b0;
  coh_result_t pin_value;
  int          error_count = 0;
  int          results_checked = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s after %0d results: got %0d, expected %0d",
             field, results_checked, got, want);
    error_count++;
  endtask

  function automatic int find_line(logic [TAG_W-1:0] tag);
    for (int i = 0; i < LINES; i++)
      if (line_st[i] != ST_I && line_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic int pick_victim();
    int v;
    logic [STAMP_W-1:0] best;
    v = 0;
    best = '1;
    for (int i = 0; i < LINES; i++)
      if (line_st[i] == ST_I) return i;
    // Ties go to the highest index, hence the less-or-equal.
    for (int i = 0; i < LINES; i++)
      if (line_stamp[i] <= best) begin
        best = line_stamp[i];
        v = i;
      end
    return v;
  endfunction

  function automatic coh_result_t predict_coherence(logic [2:0] mode,
                                                     logic [31:0] addr,
                                                     logic copy);
    coh_result_t r;
    logic [TAG_W-1:0] tag;
    int idx, v;
    line_state_t s;
    r = '0;
    tag = addr >> shift_bits;
    idx = find_line(tag);
    if (mode == MODE_RD || mode == MODE_WR) begin
      if (idx >= 0) begin
        r.hit = 1'b1;
        if (mode == MODE_RD) begin
          r.lat = rd_hit_lat;
        end else begin
          r.lat = wr_hit_lat;
          if (line_st[idx] == ST_S || line_st[idx] == ST_O) r.bus = BUS_UPGR;
          line_st[idx] = ST_M;
        end
      end else begin
        v = pick_victim();
        r.wb = (line_st[v] == ST_M || line_st[v] == ST_O);
        line_tag[v] = tag;
        line_stamp[v] = fill_count;
        fill_count = fill_count + 1;
        if (copy) begin
          r.lat = xfer_lat;
          r.bus = (mode == MODE_RD) ? BUS_RD : BUS_RDX;
        end else begin
          r.lat = mem_lat;
          r.mem = 1'b1;
        end
        if (mode == MODE_WR) line_st[v] = ST_M;
        else line_st[v] = copy ? ST_S : ST_E;
      end
    end else if (mode == MODE_BUSRD || mode == MODE_BUSRDX || mode == MODE_BUSUPGR) begin
      if (idx < 0) begin
        r.err = 1'b1;
      end else begin
        s = line_st[idx];
        r.hit = 1'b1;
        if (mode == MODE_BUSRD) begin
          if (moesi_on) begin
            if (s == ST_E) begin
              line_st[idx] = ST_S;
            end else if (s == ST_M || s == ST_O) begin
              r.flush = 1'b1;
              line_st[idx] = ST_O;
            end
          end else begin
            r.flush = 1'b1;
            line_st[idx] = ST_S;
          end
        end else if (mode == MODE_BUSRDX) begin
          r.flush = !moesi_on || s == ST_M || s == ST_O;
          r.inv = 1'b1;
          line_st[idx] = ST_I;
        end else begin
          r.err = (s == ST_M || s == ST_E);
          r.inv = 1'b1;
          line_st[idx] = ST_I;
        end
      end
    end
    return r;
  endfunction

  // Input acceptance feeds the predictor; result acceptance is checked.
  always @(posedge clk) begin
    coh_result_t got, want, pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.bus_request, out_ch.latency, out_ch.hit, out_ch.flush,
                out_ch.invalidated, out_ch.memory_access, out_ch.writeback,
                out_ch.protocol_error};
        if (expected_results.size() == 0) begin
          $display("result arrived with no transaction outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.bus != want.bus) report_mismatch("bus_request", got.bus, want.bus);
          if (got.lat != want.lat) report_mismatch("latency", got.lat, want.lat);
          if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.flush != want.flush) report_mismatch("flush", got.flush, want.flush);
          if (got.inv != want.inv) report_mismatch("invalidated", got.inv, want.inv);
          if (got.mem != want.mem) report_mismatch("memory_access", got.mem, want.mem);
          if (got.wb != want.wb) report_mismatch("writeback", got.wb, want.wb);
          if (got.err != want.err) report_mismatch("protocol_error", got.err, want.err);
        end
        results_checked++;
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = predict_coherence(in_ch.mode, in_ch.line_address, in_ch.copy_elsewhere);
        expected_results.push_back(pin_next ? pin_value : pred);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[snooping_coherence_controller] ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_item(logic [2:0] mode, logic [31:0] addr, logic copy,
                           logic pinned, coh_result_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.line_address = addr;
    in_ch.copy_elsewhere = copy;
    pin_next = pinned;
    pin_value = exp;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    pin_next = 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (LINES + 8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_PROTOCOL: moesi_on = data[0];
      CFG_OFFSET:   shift_bits = data[3:0];
      CFG_RD_HIT:   rd_hit_lat = data;
      CFG_WR_HIT:   wr_hit_lat = data;
      CFG_MEMORY:   mem_lat = data;
      CFG_TRANSFER: xfer_lat = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_row(logic [2:0] mode, logic [31:0] addr, logic copy,
                         logic pinned, coh_result_t exp);
    stim_row_t row;
    row.mode = mode;
    row.addr = addr;
    row.copy = copy;
    row.pinned = pinned;
    row.exp = exp;
    stim_table.push_back(row);
  endtask

  initial begin
    logic [31:0] base, addr, low_mask;
    logic [2:0]  mode;
    int          pick, k;
    coh_result_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_RD;
    in_ch.line_address = '0;
    in_ch.copy_elsewhere = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      line_tag[i] = '0;
      line_st[i] = ST_I;
      line_stamp[i] = '0;
    end
    fill_count = '0;
    moesi_on = 1'b0;
    shift_bits = 4'd6;
    rd_hit_lat = 8'd1;
    wr_hit_lat = 8'd1;
    mem_lat = 8'd100;
    xfer_lat = 8'd10;

    // Snoops on an empty cache, unused codes, fills and MESI transitions.
    add_row(MODE_BUSRD, 32'h0, 1'b0, 1'b1, '{BUS_NONE, 8'd0, 0, 0, 0, 0, 0, 1});
    add_row(MODE_BUSRDX, 32'hFFFF_FFFF, 1'b1, 1'b1, '{BUS_NONE, 8'd0, 0, 0, 0, 0, 0, 1});
    add_row(MODE_BUSUPGR, 32'h40, 1'b0, 1'b1, '{BUS_NONE, 8'd0, 0, 0, 0, 0, 0, 1});
    add_row(3'd5, 32'h0, 1'b0, 1'b1, none);
    add_row(3'd6, 32'h5555_5555, 1'b1, 1'b1, none);
    add_row(3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, none);
    add_row(MODE_RD, 32'h0, 1'b0, 1'b1, '{BUS_NONE, 8'd100, 0, 0, 0, 1, 0, 0});
    add_row(MODE_RD, 32'h3F, 1'b1, 1'b1, '{BUS_NONE, 8'd1, 1, 0, 0, 0, 0, 0});
    add_row(MODE_WR, 32'h0, 1'b0, 1'b1, '{BUS_NONE, 8'd1, 1, 0, 0, 0, 0, 0});
    add_row(MODE_BUSRD, 32'h0, 1'b0, 1'b0, none);
    add_row(MODE_WR, 32'h0, 1'b1, 1'b0, none);
    add_row(MODE_BUSUPGR, 32'h0, 1'b0, 1'b0, none);
    add_row(MODE_RD, 32'hFFFF_FFFF, 1'b1, 1'b1, '{BUS_RD, 8'd10, 0, 0, 0, 0, 0, 0});
    add_row(MODE_WR, 32'h80, 1'b1, 1'b1, '{BUS_RDX, 8'd10, 0, 0, 0, 0, 0, 0});
    add_row(MODE_BUSRDX, 32'h80, 1'b0, 1'b0, none);
    add_row(MODE_WR, 32'h100, 1'b0, 1'b0, none);
    add_row(MODE_RD, 32'h140, 1'b0, 1'b0, none);
    add_row(MODE_BUSUPGR, 32'h140, 1'b0, 1'b0, none);
    add_row(MODE_RD, 32'h200, 1'b1, 1'b0, none);
    add_row(MODE_BUSUPGR, 32'h200, 1'b0, 1'b0, none);
    add_row(MODE_RD, 32'h240, 1'b1, 1'b0, none);
    add_row(MODE_BUSRDX, 32'h240, 1'b0, 1'b0, none);
    add_row(MODE_BUSRD, 32'hFFFF_FFC0, 1'b0, 1'b0, none);

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 85;
    foreach (stim_table[i])
      send_item(stim_table[i].mode, stim_table[i].addr, stim_table[i].copy,
                stim_table[i].pinned, stim_table[i].exp);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // The cache keeps its contents across phases, so owned lines meet MESI rules.
      wait_drained();
      case (p)
        0: begin
          write_reg(CFG_PROTOCOL, 8'd1); write_reg(CFG_OFFSET, 8'd0);
          write_reg(CFG_RD_HIT, 8'd0); write_reg(CFG_WR_HIT, 8'd0);
          write_reg(CFG_MEMORY, 8'd0); write_reg(CFG_TRANSFER, 8'd0);
        end
        1: begin
          write_reg(CFG_PROTOCOL, 8'd0); write_reg(CFG_OFFSET, 8'd12);
          write_reg(CFG_RD_HIT, 8'd255); write_reg(CFG_WR_HIT, 8'd255);
          write_reg(CFG_MEMORY, 8'd255); write_reg(CFG_TRANSFER, 8'd255);
        end
        default: begin
          write_reg(CFG_PROTOCOL, (p % 2 == 0) ? 8'd1 : 8'd0);
          write_reg(CFG_OFFSET, 8'($urandom_range(12)));
          write_reg(CFG_RD_HIT, 8'($urandom));
          write_reg(CFG_WR_HIT, 8'($urandom));
          write_reg(CFG_MEMORY, 8'($urandom));
          write_reg(CFG_TRANSFER, 8'($urandom));
        end
      endcase
      if (p < 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 85;
      end else if (p < 6) begin
        send_idle_pct = 85;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      base = $urandom;
      low_mask = (32'd1 << shift_bits) - 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // A pool of 96 lines against 64 ways forces steady eviction.
        k = $urandom_range(95);
        addr = ((((base >> shift_bits) + k) << shift_bits) | ($urandom & low_mask));
        if ($urandom_range(9) == 0) addr = $urandom;
        pick = $urandom_range(99);
        if (pick < 30) mode = MODE_RD;
        else if (pick < 60) mode = MODE_WR;
        else if (pick < 75) mode = MODE_BUSRD;
        else if (pick < 85) mode = MODE_BUSRDX;
        else if (pick < 95) mode = MODE_BUSUPGR;
        else mode = 3'($urandom_range(7, 5));
        send_item(mode, addr, 1'($urandom), 1'b0, none);
      end
    end

    wait_drained();
    $display("checked %0d results: directed table plus %0d random phases,",
             results_checked, RANDOM_PHASES);
    $display("covering MESI and MOESI, offsets 0 to 12 and latency extremes.");
    if (error_count == 0) begin
      $display("[snooping_coherence_controller] OK");
    end else begin
      $display("[snooping_coherence_controller] ERROR");
    end
    $finish;
  end

endmodule
